@@ rtl/core/lpff_pkg.sv @@
package lpff_pkg;

  // sizes of the stream fields
  localparam int RING_BYTES_DEF = 4096;
  localparam int HDR_BYTES      = 4;
  localparam int FUNC_W         = 2;
  localparam int LEN_W          = 13;
  localparam int BYTE_W         = 8;
  localparam int DROP_W         = 11;
  localparam int ST_W           = 3;
  localparam int HDR_W          = 8 * HDR_BYTES;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 32;

  // operation selector on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_OPEN  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  typedef enum logic [ST_W-1:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_TOO_BIG  = 3'd2,
    STS_TOO_LONG = 3'd3,
    STS_BUSY     = 3'd4,
    STS_NO_FRAME = 3'd5
  } status_t;

  // source of the frame length reported with a result
  typedef enum logic [2:0] {
    FL_NONE,
    FL_WLEN,
    FL_LEN,
    FL_RLEN,
    FL_HDR
  } flen_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ROOM,
    S_DROP_HDR,
    S_READ_HDR,
    S_READ_CHK,
    S_POP,
    S_WR_HDR,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic      capture;
    logic      hdr_clr;
    logic      hdr_issue;
    logic      rd_byte;
    logic      wr_hdr;
    logic      wr_data;
    logic      drop_read;
    logic      drop_all;
    logic      drop_frame;
    logic      open_read;
    logic      pop;
    logic      set_write;
    logic      set_st;
    status_t   st;
    flen_src_t flen_src;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              wopen;
    logic              ropen;
    logic              too_big;
    logic              need_room;
    logic              held_lt_hdr;
    logic              held_zero;
    logic              hdr_long;
    logic              hdr_zero;
    logic [2:0]        iss_cnt;
    logic              got_all;
    logic              out_free;
  } sts_t;

endpackage

@@ rtl/core/lpff_ctrl.sv @@
module lpff_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lpff_pkg::sts_t sts,
  output lpff_pkg::cmd_t cmd
);
  import lpff_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.func)
          FUNC_OPEN: begin
            if (sts.wopen || sts.too_big) state_nxt = S_DONE;
            else state_nxt = S_ROOM;
          end
          FUNC_READ: begin
            if (sts.ropen) state_nxt = S_READ_CHK;
            else if (sts.held_lt_hdr) state_nxt = S_DONE;
            else state_nxt = S_READ_HDR;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_ROOM: begin
        if (!sts.need_room) state_nxt = S_WR_HDR;
        else if (!sts.ropen && !sts.held_lt_hdr) state_nxt = S_DROP_HDR;
      end
      S_DROP_HDR: begin
        if (sts.got_all) state_nxt = S_ROOM;
      end
      S_READ_HDR: begin
        if (sts.got_all) begin
          if (sts.hdr_long || sts.hdr_zero) state_nxt = S_DONE;
          else state_nxt = S_READ_CHK;
        end
      end
      S_READ_CHK: begin
        if (sts.held_zero) state_nxt = S_DONE;
        else state_nxt = S_POP;
      end
      S_POP: state_nxt = S_DONE;
      S_WR_HDR: begin
        if (sts.iss_cnt == 3'(HDR_BYTES - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_DISPATCH: begin
        case (sts.func)
          FUNC_OPEN: begin
            if (sts.wopen) begin
              cmd.set_st   = 1'b1;
              cmd.st       = STS_BUSY;
              cmd.flen_src = FL_WLEN;
            end else if (sts.too_big) begin
              cmd.set_st   = 1'b1;
              cmd.st       = STS_TOO_BIG;
              cmd.flen_src = FL_LEN;
            end
          end
          FUNC_WRITE: begin
            if (!sts.wopen) begin
              cmd.set_st = 1'b1;
              cmd.st     = STS_NO_FRAME;
            end else begin
              cmd.wr_data  = 1'b1;
              cmd.flen_src = FL_WLEN;
            end
          end
          FUNC_READ: begin
            if (sts.ropen) begin
              cmd.flen_src = FL_RLEN;
            end else if (sts.held_lt_hdr) begin
              cmd.set_st = 1'b1;
              cmd.st     = STS_EMPTY;
            end else begin
              cmd.hdr_clr = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_ROOM: begin
        if (!sts.need_room) cmd.hdr_clr = 1'b1;
        else if (sts.ropen) cmd.drop_read = 1'b1;
        else if (sts.held_lt_hdr) cmd.drop_all = 1'b1;
        else cmd.hdr_clr = 1'b1;
      end
      S_DROP_HDR: begin
        cmd.hdr_issue  = (sts.iss_cnt != 3'(HDR_BYTES));
        cmd.drop_frame = sts.got_all;
      end
      S_READ_HDR: begin
        cmd.hdr_issue = (sts.iss_cnt != 3'(HDR_BYTES));
        if (sts.got_all) begin
          cmd.flen_src = FL_HDR;
          if (sts.hdr_long) begin
            cmd.set_st = 1'b1;
            cmd.st     = STS_TOO_LONG;
          end else begin
            cmd.open_read = 1'b1;
          end
        end
      end
      S_READ_CHK: begin
        if (sts.held_zero) begin
          cmd.set_st = 1'b1;
          cmd.st     = STS_EMPTY;
        end else begin
          cmd.rd_byte = 1'b1;
        end
      end
      S_POP: cmd.pop = 1'b1;
      S_WR_HDR: begin
        cmd.wr_hdr = 1'b1;
        if (sts.iss_cnt == 3'(HDR_BYTES - 1)) begin
          cmd.set_write = 1'b1;
          cmd.flen_src  = FL_LEN;
        end
      end
      S_DONE: cmd.finish = sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/lpff_dp.sv @@
module lpff_dp #(
  parameter int RING_BYTES = lpff_pkg::RING_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpff_pkg::cmd_t                cmd,
  output lpff_pkg::sts_t                sts,
  input  logic [lpff_pkg::FUNC_W-1:0]   in_func,
  input  logic [lpff_pkg::LEN_W-1:0]    in_len,
  input  logic [lpff_pkg::BYTE_W-1:0]   in_dbyte,
  input  logic [lpff_pkg::LEN_W-1:0]    in_maxl,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lpff_pkg::ST_W-1:0]     out_status,
  output logic [lpff_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last,
  output logic [lpff_pkg::LEN_W-1:0]    out_flen,
  output logic [lpff_pkg::DROP_W-1:0]   out_drop
);
  import lpff_pkg::*;

  localparam int PW   = $clog2(RING_BYTES);
  localparam int CW   = $clog2(RING_BYTES + 1);
  localparam int MW   = (CW > LEN_W) ? CW : LEN_W;
  localparam int SUMW = MW + 2;

  // byte ring
  logic [BYTE_W-1:0] mem [RING_BYTES];
  logic [BYTE_W-1:0] rd_data_r;
  logic              mem_we, mem_re;
  logic [PW-1:0]     mem_ra;
  logic [BYTE_W-1:0] mem_wd;

  // item latched at accept
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0] dbyte_r, dbyte_nxt;
  logic [LEN_W-1:0]  maxl_r, maxl_nxt;

  // ring and frame state
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic [LEN_W-1:0]  wrem_r, wrem_nxt;
  logic [LEN_W-1:0]  rrem_r, rrem_nxt;
  logic              wopen_r, wopen_nxt;
  logic              ropen_r, ropen_nxt;
  logic [LEN_W-1:0]  wlen_r, wlen_nxt;
  logic [LEN_W-1:0]  rlen_r, rlen_nxt;

  // header fetch
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [2:0]        iss_r, iss_nxt;
  logic [2:0]        got_r, got_nxt;
  logic [1:0]        lane_r, lane_nxt;
  logic              hvld_r, hvld_nxt;

  // result being built
  status_t           res_st_r, res_st_nxt;
  logic [BYTE_W-1:0] res_byte_r, res_byte_nxt;
  logic              res_last_r, res_last_nxt;
  logic [LEN_W-1:0]  res_flen_r, res_flen_nxt;
  logic [DROP_W-1:0] res_drop_r, res_drop_nxt;

  // output register
  logic              out_vld_r, out_vld_nxt;
  logic [ST_W-1:0]   out_st_r, out_st_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic [LEN_W-1:0]  out_flen_r, out_flen_nxt;
  logic [DROP_W-1:0] out_drop_r, out_drop_nxt;

  // pointer arithmetic
  logic [CW-1:0]     disc_n;
  logic              disc_en;
  logic [CW:0]       disc_sum;
  logic [PW-1:0]     disc_ptr;
  logic [PW:0]       ha_sum;
  logic [PW-1:0]     hdr_addr;
  logic [PW-1:0]     wr_inc;
  logic [CW-1:0]     held_m_hdr;
  logic [CW-1:0]     body;
  logic              rrem_lt;
  logic [BYTE_W-1:0] hdr_wbyte;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_ptr_r] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  assign held_m_hdr = held_r - CW'(HDR_BYTES);
  assign body       = (hdr_r > HDR_W'(held_m_hdr)) ? held_m_hdr : hdr_r[CW-1:0];
  assign rrem_lt    = MW'(rrem_r) < MW'(held_r);

  always_comb begin
    disc_en = cmd.drop_read | cmd.drop_all | cmd.drop_frame | cmd.open_read | cmd.pop;
    disc_n  = '0;
    if (cmd.drop_read) disc_n = rrem_lt ? CW'(rrem_r) : held_r;
    else if (cmd.drop_all) disc_n = held_r;
    else if (cmd.drop_frame) disc_n = CW'(HDR_BYTES) + body;
    else if (cmd.open_read) disc_n = CW'(HDR_BYTES);
    else if (cmd.pop) disc_n = CW'(1);
  end

  always_comb begin
    disc_sum = (CW+1)'(rd_ptr_r) + (CW+1)'(disc_n);
    if (disc_sum >= (CW+1)'(RING_BYTES)) disc_sum = disc_sum - (CW+1)'(RING_BYTES);
    disc_ptr = disc_sum[PW-1:0];
    ha_sum   = (PW+1)'(rd_ptr_r) + (PW+1)'(iss_r[1:0]);
    if (ha_sum >= (PW+1)'(RING_BYTES)) ha_sum = ha_sum - (PW+1)'(RING_BYTES);
    hdr_addr = ha_sum[PW-1:0];
    wr_inc   = (wr_ptr_r == PW'(RING_BYTES - 1)) ? '0 : wr_ptr_r + PW'(1);
  end

  // little-endian length header, upper bytes always zero
  always_comb begin
    case (iss_r[1:0])
      2'd0:    hdr_wbyte = len_r[7:0];
      2'd1:    hdr_wbyte = BYTE_W'(len_r[LEN_W-1:8]);
      default: hdr_wbyte = '0;
    endcase
  end

  always_comb begin
    func_nxt     = func_r;
    len_nxt      = len_r;
    dbyte_nxt    = dbyte_r;
    maxl_nxt     = maxl_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    held_nxt     = held_r;
    wrem_nxt     = wrem_r;
    rrem_nxt     = rrem_r;
    wopen_nxt    = wopen_r;
    ropen_nxt    = ropen_r;
    wlen_nxt     = wlen_r;
    rlen_nxt     = rlen_r;
    hdr_nxt      = hdr_r;
    iss_nxt      = iss_r;
    got_nxt      = got_r;
    lane_nxt     = iss_r[1:0];
    hvld_nxt     = cmd.hdr_issue;
    res_st_nxt   = res_st_r;
    res_byte_nxt = res_byte_r;
    res_last_nxt = res_last_r;
    res_flen_nxt = res_flen_r;
    res_drop_nxt = res_drop_r;
    out_vld_nxt  = out_vld_r;
    out_st_nxt   = out_st_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_flen_nxt = out_flen_r;
    out_drop_nxt = out_drop_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_ra       = rd_ptr_r;
    mem_wd       = dbyte_r;

    if (cmd.capture) begin
      func_nxt     = in_func;
      len_nxt      = in_len;
      dbyte_nxt    = in_dbyte;
      maxl_nxt     = in_maxl;
      res_st_nxt   = STS_OK;
      res_byte_nxt = '0;
      res_last_nxt = 1'b0;
      res_flen_nxt = '0;
      res_drop_nxt = '0;
    end

    if (cmd.hdr_clr) begin
      iss_nxt = '0;
      got_nxt = '0;
    end
    if (cmd.hdr_issue) begin
      mem_re  = 1'b1;
      mem_ra  = hdr_addr;
      iss_nxt = iss_r + 3'd1;
    end
    if (hvld_r) begin
      hdr_nxt[8*lane_r +: 8] = rd_data_r;
      got_nxt = got_r + 3'd1;
    end

    if (cmd.rd_byte) mem_re = 1'b1;

    if (cmd.wr_hdr) begin
      mem_we     = 1'b1;
      mem_wd     = hdr_wbyte;
      wr_ptr_nxt = wr_inc;
      held_nxt   = held_r + CW'(1);
      iss_nxt    = iss_r + 3'd1;
    end
    if (cmd.wr_data) begin
      mem_we     = 1'b1;
      wr_ptr_nxt = wr_inc;
      held_nxt   = held_r + CW'(1);
      wrem_nxt   = wrem_r - LEN_W'(1);
      if (wrem_r == LEN_W'(1)) begin
        wopen_nxt    = 1'b0;
        res_last_nxt = 1'b1;
      end
    end
    if (cmd.set_write) begin
      wlen_nxt     = len_r;
      wrem_nxt     = len_r;
      wopen_nxt    = (len_r != '0);
      res_last_nxt = (len_r == '0);
    end

    if (disc_en) begin
      rd_ptr_nxt = disc_ptr;
      held_nxt   = held_r - disc_n;
    end
    if (cmd.drop_read) begin
      ropen_nxt = 1'b0;
      rrem_nxt  = '0;
    end
    if ((cmd.drop_read || cmd.drop_all || cmd.drop_frame) &&
        (res_drop_r != {DROP_W{1'b1}})) begin
      res_drop_nxt = res_drop_r + DROP_W'(1);
    end
    if (cmd.open_read) begin
      rlen_nxt = hdr_r[LEN_W-1:0];
      if (sts.hdr_zero) begin
        res_last_nxt = 1'b1;
      end else begin
        ropen_nxt = 1'b1;
        rrem_nxt  = hdr_r[LEN_W-1:0];
      end
    end
    if (cmd.pop) begin
      res_byte_nxt = rd_data_r;
      rrem_nxt     = rrem_r - LEN_W'(1);
      if (rrem_r == LEN_W'(1)) begin
        ropen_nxt    = 1'b0;
        res_last_nxt = 1'b1;
      end
    end

    if (cmd.set_st) res_st_nxt = cmd.st;
    case (cmd.flen_src)
      FL_WLEN: res_flen_nxt = wlen_r;
      FL_LEN:  res_flen_nxt = len_r;
      FL_RLEN: res_flen_nxt = rlen_r;
      FL_HDR:  res_flen_nxt = hdr_r[LEN_W-1:0];
      default: ;
    endcase

    if (cmd.finish) begin
      out_vld_nxt  = 1'b1;
      out_st_nxt   = res_st_r;
      out_byte_nxt = res_byte_r;
      out_last_nxt = res_last_r;
      out_flen_nxt = res_flen_r;
      out_drop_nxt = res_drop_r;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      held_r    <= '0;
      wrem_r    <= '0;
      rrem_r    <= '0;
      wopen_r   <= 1'b0;
      ropen_r   <= 1'b0;
      wlen_r    <= '0;
      rlen_r    <= '0;
      iss_r     <= '0;
      got_r     <= '0;
      hvld_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      held_r    <= held_nxt;
      wrem_r    <= wrem_nxt;
      rrem_r    <= rrem_nxt;
      wopen_r   <= wopen_nxt;
      ropen_r   <= ropen_nxt;
      wlen_r    <= wlen_nxt;
      rlen_r    <= rlen_nxt;
      iss_r     <= iss_nxt;
      got_r     <= got_nxt;
      hvld_r    <= hvld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    len_r      <= len_nxt;
    dbyte_r    <= dbyte_nxt;
    maxl_r     <= maxl_nxt;
    hdr_r      <= hdr_nxt;
    lane_r     <= lane_nxt;
    res_st_r   <= res_st_nxt;
    res_byte_r <= res_byte_nxt;
    res_last_r <= res_last_nxt;
    res_flen_r <= res_flen_nxt;
    res_drop_r <= res_drop_nxt;
    out_st_r   <= out_st_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_flen_r <= out_flen_nxt;
    out_drop_r <= out_drop_nxt;
  end

  always_comb begin
    sts.func        = func_r;
    sts.wopen       = wopen_r;
    sts.ropen       = ropen_r;
    sts.too_big     = (SUMW'(len_r) + SUMW'(HDR_BYTES)) > SUMW'(RING_BYTES);
    sts.need_room   = (SUMW'(held_r) + SUMW'(len_r) + SUMW'(HDR_BYTES)) > SUMW'(RING_BYTES);
    sts.held_lt_hdr = held_r < CW'(HDR_BYTES);
    sts.held_zero   = (held_r == '0);
    sts.hdr_long    = hdr_r > HDR_W'(maxl_r);
    sts.hdr_zero    = (hdr_r == '0);
    sts.iss_cnt     = iss_r;
    sts.got_all     = (got_r == 3'(HDR_BYTES));
    sts.out_free    = !out_vld_r || out_ready;
  end

  assign out_valid  = out_vld_r;
  assign out_status = out_st_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_flen   = out_flen_r;
  assign out_drop   = out_drop_r;

  // write pointer always sits held bytes past the read pointer
  logic [CW:0]   chk_sum;
  logic [PW-1:0] chk_ptr;
  always_comb begin
    chk_sum = (CW+1)'(rd_ptr_r) + (CW+1)'(held_r);
    if (chk_sum >= (CW+1)'(RING_BYTES)) chk_sum = chk_sum - (CW+1)'(RING_BYTES);
    chk_ptr = chk_sum[PW-1:0];
  end

  a_ptr_held: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == chk_ptr)
    else $error("ring pointers out of step with byte count");

  a_held_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(RING_BYTES))
    else $error("ring holds more bytes than it has");

  a_open_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (ropen_r |-> rrem_r != '0) and (wopen_r |-> wrem_r != '0))
    else $error("open frame with nothing remaining");

  a_ring_ops: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_hdr, cmd.wr_data, cmd.drop_read, cmd.drop_all,
              cmd.drop_frame, cmd.open_read, cmd.pop}))
    else $error("two ring updates in one cycle");

endmodule

@@ rtl/core/length_prefixed_frame_fifo.sv @@
// Frame FIFO over a byte ring (RING_BYTES deep, one read and one write port).
// Each stored frame is a 4-byte little-endian length header followed by its
// payload. in_tuser picks the operation: 0 opens a frame of element_length
// bytes, 1 writes one payload byte, 2 reads the next payload byte (checked
// against max_length at the start of a frame). Opening a frame that does not
// fit drops the oldest frames first and reports how many. Every input word
// gives exactly one result word. Items are handled one at a time by a
// controller walking a small datapath. A read at a frame start first fetches
// the length header (four header byte reads); an open first drops frames
// until the new one fits. A finished result waits in the output register, so
// the next word is accepted while out_tready is low; only the following
// result then stalls. There is no clearing pass after reset: the ring is
// never read where it has not been written.
module length_prefixed_frame_fifo #(
  parameter int RING_BYTES = lpff_pkg::RING_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // element_length [12:0], data_byte [20:13], max_length [33:21], zero fill
  input  logic [lpff_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func [1:0]
  input  logic [lpff_pkg::FUNC_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_byte [7:0], frame_length [20:8], dropped_frames [31:21]
  output logic [lpff_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status [2:0]
  output logic [lpff_pkg::ST_W-1:0]         out_tuser,
  output logic                              out_tlast
);
  import lpff_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // unpacked input fields
  logic [LEN_W-1:0]  in_len;
  logic [BYTE_W-1:0] in_dbyte;
  logic [LEN_W-1:0]  in_maxl;

  // result fields before packing
  logic [BYTE_W-1:0] res_byte;
  logic [LEN_W-1:0]  res_flen;
  logic [DROP_W-1:0] res_drop;

  assign in_len   = in_tdata[LEN_W-1:0];
  assign in_dbyte = in_tdata[LEN_W +: BYTE_W];
  assign in_maxl  = in_tdata[LEN_W+BYTE_W +: LEN_W];

  // sequencer: one operation at a time, issues ring commands
  lpff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring memory, pointers, frame state and the output register
  lpff_dp #(
    .RING_BYTES (RING_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_tuser),
    .in_len     (in_len),
    .in_dbyte   (in_dbyte),
    .in_maxl    (in_maxl),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_byte   (res_byte),
    .out_last   (out_tlast),
    .out_flen   (res_flen),
    .out_drop   (res_drop)
  );

  assign out_tdata = {res_drop, res_flen, res_byte};

endmodule
